>>> hw/rtl/dpsm_pkg.sv
`default_nettype none

package dpsm_pkg;

  typedef enum logic [2:0] {
    ST_NOT_READY   = 3'd0,
    ST_DISABLED    = 3'd1,
    ST_READY       = 3'd2,
    ST_ON          = 3'd3,
    ST_OPEN        = 3'd4,
    ST_QSTOP       = 3'd5,
    ST_FAULT_REACT = 3'd6,
    ST_FAULT       = 3'd7
  } state_t;

  typedef enum logic {
    REQ_CONTROL = 1'b0,
    REQ_TARGET  = 1'b1
  } req_t;

  // controlword bit positions
  localparam int unsigned CW_SO   = 0;
  localparam int unsigned CW_EV   = 1;
  localparam int unsigned CW_QS   = 2;
  localparam int unsigned CW_EO   = 3;
  localparam int unsigned CW_NSP  = 4;
  localparam int unsigned CW_REL  = 6;
  localparam int unsigned CW_FR   = 7;
  localparam int unsigned CW_HALT = 8;

  // statusword masks
  localparam logic [15:0] SW_RTSO  = 16'h0001;
  localparam logic [15:0] SW_SON   = 16'h0002;
  localparam logic [15:0] SW_OPEN  = 16'h0004;
  localparam logic [15:0] SW_FLT   = 16'h0008;
  localparam logic [15:0] SW_QS    = 16'h0020;
  localparam logic [15:0] SW_SOD   = 16'h0040;
  localparam logic [15:0] SW_TR    = 16'h0400;
  localparam logic [15:0] SW_OMS0  = 16'h1000;

  function automatic logic [15:0] set_clr(logic [15:0] sw, logic [15:0] setm,
                                          logic [15:0] clrm);
    return (sw | setm) & ~clrm;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/drive_power_state_machine.sv
// A result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle while no held result stalls the input;
// the drive state and result registers update together in the accepting cycle.
// Reset (rst, synchronous, active high): drive goes to not ready, statusword,
// mode, motion flags and last controlword clear, and the output is empty.
`default_nettype none

module drive_power_state_machine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] control_word, [23:16] op_mode, [24] reached, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] req_type
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] status_word, [18:16] drive_state_out, [26:19] mode_display,
  // [27] relative_flag, [28] halt_flag, [29] new_setpoint_flag, [31:30] zero
  output logic [31:0]      m_axis_tdata
);

  dpsm_pkg::state_t state, state_next;
  logic [15:0] last_control, last_control_next;
  logic [15:0] status_reg, status_reg_next;
  logic [7:0]  mode_reg, mode_reg_next;
  logic [2:0]  motion_flags, motion_flags_next;

  logic        accept;
  logic [15:0] cw;
  logic [7:0]  op_mode;
  logic        reached;
  dpsm_pkg::req_t req;

  logic fr0, ev, qs, so, eo;
  logic c_shutdown, c_disable, c_switch_on, c_enable, c_qstop, c_reset;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cw            = s_axis_tdata[15:0];
  assign op_mode       = s_axis_tdata[23:16];
  assign reached       = s_axis_tdata[24];
  assign req           = dpsm_pkg::req_t'(s_axis_tuser);

  assign fr0 = !cw[dpsm_pkg::CW_FR];
  assign ev  = cw[dpsm_pkg::CW_EV];
  assign qs  = cw[dpsm_pkg::CW_QS];
  assign so  = cw[dpsm_pkg::CW_SO];
  assign eo  = cw[dpsm_pkg::CW_EO];

  assign c_shutdown  = fr0 && qs && ev && !so;
  assign c_disable   = fr0 && !ev;
  assign c_switch_on = fr0 && !eo && qs && ev && so;
  assign c_enable    = fr0 && eo && qs && ev && so;
  assign c_qstop     = fr0 && !qs && ev;
  assign c_reset     = !fr0;

  // target statusword values for each move
  logic [15:0] sw_disabled, sw_ready, sw_on, sw_open, sw_qstop;

  assign sw_disabled = dpsm_pkg::set_clr(status_reg, dpsm_pkg::SW_SOD,
                         dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN |
                         dpsm_pkg::SW_FLT);
  assign sw_ready    = dpsm_pkg::set_clr(status_reg, dpsm_pkg::SW_RTSO | dpsm_pkg::SW_QS,
                         dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN | dpsm_pkg::SW_FLT |
                         dpsm_pkg::SW_SOD);
  assign sw_on       = dpsm_pkg::set_clr(status_reg,
                         dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_QS,
                         dpsm_pkg::SW_OPEN | dpsm_pkg::SW_FLT | dpsm_pkg::SW_SOD);
  assign sw_open     = dpsm_pkg::set_clr(status_reg,
                         dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN |
                         dpsm_pkg::SW_QS,
                         dpsm_pkg::SW_SOD | dpsm_pkg::SW_FLT);
  assign sw_qstop    = dpsm_pkg::set_clr(status_reg,
                         dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN,
                         dpsm_pkg::SW_QS | dpsm_pkg::SW_SOD | dpsm_pkg::SW_FLT);

  always_comb begin
    state_next        = state;
    last_control_next = last_control;
    status_reg_next   = status_reg;
    mode_reg_next     = mode_reg;
    motion_flags_next = motion_flags;
    if (accept) begin
      unique case (req)
        dpsm_pkg::REQ_CONTROL: begin
          mode_reg_next = op_mode;
          if (cw != last_control) begin
            last_control_next = cw;
            // command decodes are mutually exclusive
            unique case (state)
              dpsm_pkg::ST_NOT_READY: begin
                state_next      = dpsm_pkg::ST_DISABLED;
                status_reg_next = sw_disabled;
              end
              dpsm_pkg::ST_DISABLED: begin
                if (c_shutdown) begin
                  state_next      = dpsm_pkg::ST_READY;
                  status_reg_next = sw_ready;
                end
              end
              dpsm_pkg::ST_READY: begin
                if (c_disable) begin
                  state_next      = dpsm_pkg::ST_DISABLED;
                  status_reg_next = sw_disabled;
                end else if (c_switch_on) begin
                  state_next      = dpsm_pkg::ST_ON;
                  status_reg_next = sw_on;
                end else if (c_reset) begin
                  state_next      = dpsm_pkg::ST_READY;
                  status_reg_next = sw_ready;
                end
              end
              dpsm_pkg::ST_ON: begin
                if (c_disable) begin
                  state_next      = dpsm_pkg::ST_DISABLED;
                  status_reg_next = sw_disabled;
                end else if (c_shutdown) begin
                  state_next      = dpsm_pkg::ST_READY;
                  status_reg_next = sw_ready;
                end else if (c_enable) begin
                  state_next      = dpsm_pkg::ST_OPEN;
                  status_reg_next = sw_open;
                end
              end
              dpsm_pkg::ST_OPEN: begin
                if (c_disable) begin
                  state_next      = dpsm_pkg::ST_DISABLED;
                  status_reg_next = sw_disabled;
                end else if (c_shutdown) begin
                  state_next      = dpsm_pkg::ST_READY;
                  status_reg_next = sw_ready;
                end else if (c_switch_on) begin
                  state_next      = dpsm_pkg::ST_ON;
                  status_reg_next = sw_on;
                end else if (c_qstop) begin
                  state_next      = dpsm_pkg::ST_QSTOP;
                  status_reg_next = sw_qstop;
                end
                motion_flags_next = {cw[dpsm_pkg::CW_NSP], cw[dpsm_pkg::CW_HALT],
                                     cw[dpsm_pkg::CW_REL]};
              end
              dpsm_pkg::ST_QSTOP: begin
                if (c_enable) begin
                  state_next      = dpsm_pkg::ST_OPEN;
                  status_reg_next = sw_open;
                end else if (c_disable) begin
                  state_next      = dpsm_pkg::ST_DISABLED;
                  status_reg_next = sw_disabled;
                end
              end
              default: begin
                // fault states only record the controlword
              end
            endcase
          end
        end
        dpsm_pkg::REQ_TARGET: begin
          if (reached && !status_reg[10]) begin
            status_reg_next = dpsm_pkg::set_clr(status_reg, dpsm_pkg::SW_TR,
                                                dpsm_pkg::SW_OMS0);
          end else if (!reached && status_reg[10]) begin
            status_reg_next = dpsm_pkg::set_clr(status_reg, dpsm_pkg::SW_OMS0,
                                                dpsm_pkg::SW_TR);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dpsm_pkg::ST_NOT_READY;
      last_control  <= 16'h0000;
      status_reg    <= 16'h0000;
      mode_reg      <= 8'h00;
      motion_flags  <= 3'b000;
      m_axis_tvalid <= 1'b0;
    end else begin
      state        <= state_next;
      last_control <= last_control_next;
      status_reg   <= status_reg_next;
      mode_reg     <= mode_reg_next;
      motion_flags <= motion_flags_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {2'b00, motion_flags_next, mode_reg_next,
                       3'(state_next), status_reg_next};
    end
  end

endmodule

`default_nettype wire

>>> bench/drive_power_checker.sv
`default_nettype none

module drive_power_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // [15:0] control_word, [23:16] op_mode, [24] reached, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] req_type
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] status_word, [18:16] drive_state_out, [26:19] mode_display,
  // [27] relative_flag, [28] halt_flag, [29] new_setpoint_flag, [31:30] zero
  input  wire logic [31:0] m_axis_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [15:0]      status;
    dpsm_pkg::state_t state;
    logic [7:0]       mode;
    logic             rel;
    logic             halt;
    logic             nsp;
  } drive_report_t;

  dpsm_pkg::state_t drv_state;
  logic [15:0]      last_cw;
  logic [15:0]      sw;
  logic [7:0]       mode_q;
  logic             rel_q, halt_q, nsp_q;
  drive_report_t    expected_reports[$];

  function automatic void enter_state(dpsm_pkg::state_t s);
    logic [15:0] setm, clrm;
    setm = '0;
    clrm = '0;
    case (s)
      dpsm_pkg::ST_DISABLED: begin
        setm = dpsm_pkg::SW_SOD;
        clrm = dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN | dpsm_pkg::SW_FLT;
      end
      dpsm_pkg::ST_READY: begin
        setm = dpsm_pkg::SW_RTSO | dpsm_pkg::SW_QS;
        clrm = dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN | dpsm_pkg::SW_FLT | dpsm_pkg::SW_SOD;
      end
      dpsm_pkg::ST_ON: begin
        setm = dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_QS;
        clrm = dpsm_pkg::SW_OPEN | dpsm_pkg::SW_FLT | dpsm_pkg::SW_SOD;
      end
      dpsm_pkg::ST_OPEN: begin
        setm = dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN | dpsm_pkg::SW_QS;
        clrm = dpsm_pkg::SW_SOD | dpsm_pkg::SW_FLT;
      end
      dpsm_pkg::ST_QSTOP: begin
        setm = dpsm_pkg::SW_RTSO | dpsm_pkg::SW_SON | dpsm_pkg::SW_OPEN;
        clrm = dpsm_pkg::SW_QS | dpsm_pkg::SW_SOD | dpsm_pkg::SW_FLT;
      end
      default: ;
    endcase
    drv_state = s;
    sw = (sw | setm) & ~clrm;
  endfunction

  function automatic drive_report_t advance_drive(dpsm_pkg::req_t kind, logic [15:0] cw,
                                                  logic [7:0] m, logic rch);
    drive_report_t r;
    logic fr0, ev, qs, so, eo;
    logic c_shutdown, c_disable, c_switch_on, c_enable, c_qstop, c_reset;
    fr0 = !cw[dpsm_pkg::CW_FR];
    ev = cw[dpsm_pkg::CW_EV];
    qs = cw[dpsm_pkg::CW_QS];
    so = cw[dpsm_pkg::CW_SO];
    eo = cw[dpsm_pkg::CW_EO];
    c_shutdown = fr0 && qs && ev && !so;
    c_disable = fr0 && !ev;
    c_switch_on = fr0 && !eo && qs && ev && so;
    c_enable = fr0 && eo && qs && ev && so;
    c_qstop = fr0 && !qs && ev;
    c_reset = !fr0;
    if (kind == dpsm_pkg::REQ_CONTROL) begin
      if (cw != last_cw) begin
        last_cw = cw;
        case (drv_state)
          dpsm_pkg::ST_NOT_READY: enter_state(dpsm_pkg::ST_DISABLED);
          dpsm_pkg::ST_DISABLED: begin
            if (c_shutdown) enter_state(dpsm_pkg::ST_READY);
          end
          dpsm_pkg::ST_READY: begin
            if (c_disable) enter_state(dpsm_pkg::ST_DISABLED);
            if (c_switch_on) enter_state(dpsm_pkg::ST_ON);
            if (c_reset) enter_state(dpsm_pkg::ST_READY);
          end
          dpsm_pkg::ST_ON: begin
            if (c_disable) enter_state(dpsm_pkg::ST_DISABLED);
            if (c_shutdown) enter_state(dpsm_pkg::ST_READY);
            if (c_enable) enter_state(dpsm_pkg::ST_OPEN);
          end
          dpsm_pkg::ST_OPEN: begin
            if (c_disable) enter_state(dpsm_pkg::ST_DISABLED);
            if (c_shutdown) enter_state(dpsm_pkg::ST_READY);
            if (c_switch_on) enter_state(dpsm_pkg::ST_ON);
            if (c_qstop) enter_state(dpsm_pkg::ST_QSTOP);
            rel_q = cw[dpsm_pkg::CW_REL];
            halt_q = cw[dpsm_pkg::CW_HALT];
            nsp_q = cw[dpsm_pkg::CW_NSP];
          end
          dpsm_pkg::ST_QSTOP: begin
            if (c_enable) enter_state(dpsm_pkg::ST_OPEN);
            if (c_disable) enter_state(dpsm_pkg::ST_DISABLED);
          end
          default: ;
        endcase
      end
      mode_q = m;
    end else begin
      if (rch && !sw[10]) sw = (sw | dpsm_pkg::SW_TR) & ~dpsm_pkg::SW_OMS0;
      else if (!rch && sw[10]) sw = (sw | dpsm_pkg::SW_OMS0) & ~dpsm_pkg::SW_TR;
    end
    r.status = sw;
    r.state = drv_state;
    r.mode = mode_q;
    r.rel = rel_q;
    r.halt = halt_q;
    r.nsp = nsp_q;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_report_t want, got;
    if (rst) begin
      drv_state = dpsm_pkg::ST_NOT_READY;
      last_cw = '0;
      sw = '0;
      mode_q = '0;
      rel_q = 1'b0;
      halt_q = 1'b0;
      nsp_q = 1'b0;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[15:0];
        got.state = dpsm_pkg::state_t'(m_axis_tdata[18:16]);
        got.mode = m_axis_tdata[26:19];
        got.rel = m_axis_tdata[27];
        got.halt = m_axis_tdata[28];
        got.nsp = m_axis_tdata[29];
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: tdata=%h", m_axis_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (got.status != want.status || got.state != want.state ||
              got.mode != want.mode || got.rel != want.rel ||
              got.halt != want.halt || got.nsp != want.nsp ||
              m_axis_tdata[31:30] != 2'b00) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp sw=%h st=%0d mode=%h rel=%b halt=%b nsp=%b",
                       want.status, want.state, want.mode, want.rel, want.halt,
                       want.nsp,
                       " | got sw=%h st=%0d mode=%h rel=%b halt=%b nsp=%b pad=%b",
                       got.status, got.state, got.mode, got.rel,
                       got.halt, got.nsp, m_axis_tdata[31:30]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(advance_drive(dpsm_pkg::req_t'(s_axis_tuser),
                                                 s_axis_tdata[15:0],
                                                 s_axis_tdata[23:16],
                                                 s_axis_tdata[24]));
    end
    pending <= expected_reports.size();
  end

endmodule

`default_nettype wire

>>> bench/tb_drive_power_state_machine.sv
`default_nettype none

module tb_drive_power_state_machine;

  localparam logic [15:0] CMD_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CMD_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CMD_ENABLE      = 16'h000F;
  localparam logic [15:0] CMD_DISABLE     = 16'h0000;
  localparam logic [15:0] CMD_QSTOP       = 16'h0002;
  localparam logic [15:0] CMD_FAULT_RESET = 16'h0080;
  localparam int          RANDOM_ITEMS    = 1800;
  localparam int          IDLE_LIMIT      = 2000;
  localparam int          HOLD_CYCLES     = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          sent_items = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          held_off = 1'b0;

  always #2 clk = ~clk;

  drive_power_state_machine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drive_power_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // one item; the sender drops valid only between bursts
  task automatic send_item(dpsm_pkg::req_t kind, logic [15:0] cw, logic [7:0] m,
                           logic rch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'b0, rch, m, cw};
    do @(posedge clk); while (!s_axis_tready);
    sent_items++;
  endtask

  function automatic logic [15:0] pick_control(logic [15:0] prev);
    logic [15:0] noise;
    int sel;
    noise = 16'($urandom) & 16'hFF70;
    sel = $urandom_range(0, 19);
    if (sel < 4) return CMD_SHUTDOWN | noise;
    if (sel < 8) return CMD_SWITCH_ON | noise;
    if (sel < 12) return CMD_ENABLE | noise;
    if (sel < 14) return CMD_DISABLE | noise | (16'($urandom) & 16'h000D);
    if (sel < 16) return CMD_QSTOP | noise | (16'($urandom) & 16'h0009);
    if (sel == 16) return CMD_FAULT_RESET | noise | (16'($urandom) & 16'h007F);
    if (sel == 17) return prev;
    return 16'($urandom);
  endfunction

  // receiver: ready runs, random stalls, and one long hold-off
  initial begin
    int kind, len;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && sent_items >= 400) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 2);
        len = $urandom_range(5, 40);
        repeat (len) begin
          case (kind)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cw;
    dpsm_pkg::req_t kind;
    cw = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed walk through the drive states
    send_item(dpsm_pkg::REQ_TARGET, 16'hFFFF, 8'h80, 1'b1);
    send_item(dpsm_pkg::REQ_TARGET, 16'h0000, 8'h7F, 1'b1);
    send_item(dpsm_pkg::REQ_TARGET, 16'h0000, 8'h00, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, 16'h0000, 8'h05, 1'b0);        // same word, mode only
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h80, 1'b0);     // leaves not ready
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h7F, 1'b1);     // same word
    send_item(dpsm_pkg::REQ_CONTROL, 16'hFFFF, 8'hFF, 1'b1);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h01, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN | CMD_FAULT_RESET, 8'h02, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SWITCH_ON, 8'h03, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_ENABLE, 8'h04, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_ENABLE | 16'h0150, 8'h06, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_QSTOP | 16'h0001, 8'hFE, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_ENABLE, 8'h07, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SWITCH_ON, 8'h08, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h09, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_DISABLE, 8'h0A, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h0B, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SWITCH_ON, 8'h0C, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_ENABLE, 8'h0D, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SHUTDOWN, 8'h0E, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, CMD_SWITCH_ON, 8'h0F, 1'b0);
    send_item(dpsm_pkg::REQ_CONTROL, 16'h0005, 8'h10, 1'b0);

    repeat (RANDOM_ITEMS) begin
      kind = ($urandom_range(0, 4) == 0) ? dpsm_pkg::REQ_TARGET : dpsm_pkg::REQ_CONTROL;
      if (kind == dpsm_pkg::REQ_CONTROL) cw = pick_control(cw);
      send_item(kind, (kind == dpsm_pkg::REQ_CONTROL) ? cw : 16'($urandom),
                8'($urandom), 1'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
